/* rtl/rmis_pkg.sv */
`timescale 1ns / 1ps
// rmis_pkg: opcodes, status codes, cost constants and default sizes
// for the register machine instruction step core. No dependencies.
package rmis_pkg;

	localparam int unsigned DEF_MEM_AW     = 10;    // 1024 data words
	localparam int unsigned DEF_PROG_DEPTH = 4096;

	localparam int unsigned NUM_REGS = 8;
	localparam int unsigned REG_IW   = 3;
	localparam int unsigned WORD_W   = 64;
	localparam int unsigned LEN_W    = 13;
	localparam int unsigned TGT_W    = 12;

	localparam logic [WORD_W-1:0] COST_MEM    = 64'd50;
	localparam logic [WORD_W-1:0] COST_IO     = 64'd100;
	localparam logic [WORD_W-1:0] COST_ARITH  = 64'd5;
	localparam logic [WORD_W-1:0] COST_SIMPLE = 64'd1;

	typedef enum logic [4:0] {
		OP_READ  = 5'd0,
		OP_WRITE = 5'd1,
		OP_LOAD  = 5'd2,
		OP_STORE = 5'd3,
		OP_ADD   = 5'd4,
		OP_SUB   = 5'd5,
		OP_GET   = 5'd6,
		OP_PUT   = 5'd7,
		OP_RST   = 5'd8,
		OP_INC   = 5'd9,
		OP_DEC   = 5'd10,
		OP_SHL   = 5'd11,
		OP_SHR   = 5'd12,
		OP_JUMP  = 5'd13,
		OP_JPOS  = 5'd14,
		OP_JZERO = 5'd15,
		OP_STRK  = 5'd16,
		OP_JUMPR = 5'd17,
		OP_HALT  = 5'd18
	} op_t;

	typedef enum logic [1:0] {
		ST_RUN  = 2'd0,
		ST_HALT = 2'd1,
		ST_ERR  = 2'd2
	} status_t;

endpackage

/* rtl/register_machine_instruction_step_core.sv */
`timescale 1ns / 1ps
// register_machine_instruction_step_core: executes one instruction of an
// eight-register accumulator machine per input transfer. Uses rmis_pkg.
//
// Usage
//  - Input stream (s_*): one instruction per transfer. s_tuser carries the
//    opcode, s_tdata the register index, jump target and read value.
//  - Output stream (m_*): exactly one result transfer per instruction, in
//    order: status and write flag in m_tuser, next pc, written value and
//    the two cost counters in m_tdata.
//  - cfg_we/cfg_wdata: writes program_length; write only while idle.
// Pipeline and throughput
//  - An accepted instruction is registered in s1 and executes from there
//    into the output register, where m_tvalid rises; the result transfer
//    completes when m_tready is high. Back-to-back instructions other than
//    LOAD go at one per cycle while m_tready stays high.
//  - LOAD waits in s1 for its data: the synchronous data memory read is
//    issued with the current register file and registered in mem_rd_q,
//    and the load executes from mem_rd_q once phase_q is set.
// Reset and stall
//  - arst_n clears the registers, pc, both counters and both valid flags,
//    and sets program_length to 1. Data memory is not cleared.
//  - When m_tready is low the result holds in the output register; s1 may
//    still take one more instruction, then s_tready drops until the
//    result moves.
// MEM_AW sets the data memory to 2**MEM_AW words; the address is the low
// MEM_AW bits of the selected register.
module register_machine_instruction_step_core
	import rmis_pkg::*;
#(
	parameter int unsigned MEM_AW     = DEF_MEM_AW,
	parameter int unsigned PROG_DEPTH = DEF_PROG_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [79:0]  s_tdata,   // reg_index[2:0], jump_target[14:3], in_value[78:15]
	input  logic [4:0]   s_tuser,   // func[4:0]
	// output stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [255:0] m_tdata,   // next_pc, out_value, time_cost, io_cost (64 b each)
	output logic [2:0]   m_tuser,   // status[1:0], out_valid[2]
	// configuration
	input  logic         cfg_we,
	input  logic [12:0]  cfg_wdata  // program_length
);

	localparam int unsigned MEM_WORDS = 1 << MEM_AW;
	localparam logic [WORD_W-1:0] DEPTH_W = WORD_W'(PROG_DEPTH);

	// ---------------- architectural state
	logic [WORD_W-1:0] regs_q [NUM_REGS];
	logic [WORD_W-1:0] pc_q;
	logic [WORD_W-1:0] time_q;
	logic [WORD_W-1:0] io_q;
	logic [LEN_W-1:0]  prog_len_q;

	// ---------------- input stage
	logic              valid_s1;
	logic [4:0]        func_s1;
	logic [REG_IW-1:0] ri_s1;
	logic [TGT_W-1:0]  tgt_s1;
	logic [WORD_W-1:0] val_s1;
	logic              phase_q;      // load read issued, data in mem_rd_q

	// ---------------- data memory
	logic [WORD_W-1:0] mem [MEM_WORDS];
	logic [WORD_W-1:0] mem_rd_q;
	logic [MEM_AW-1:0] mem_addr;
	logic              mem_we;

	// ---------------- output register
	logic              m_valid_q;
	status_t           status_q;
	logic              ovalid_q;
	logic [WORD_W-1:0] npc_q;
	logic [WORD_W-1:0] oval_q;
	logic [WORD_W-1:0] tcost_q;
	logic [WORD_W-1:0] iocost_q;

	// ---------------- execute
	logic              is_load;
	logic              fire;
	logic [WORD_W-1:0] r0;
	logic [WORD_W-1:0] rsel;
	logic              reg_we;
	logic [REG_IW-1:0] reg_wa;
	logic [WORD_W-1:0] reg_wd;
	logic [WORD_W-1:0] pc_nx;
	logic [WORD_W-1:0] time_nx;
	logic [WORD_W-1:0] io_nx;
	logic [WORD_W-1:0] len_eff;
	status_t           status_nx;
	logic              ovalid_nx;

	assign is_load  = (func_s1 == OP_LOAD);
	assign fire     = valid_s1 && (!is_load || phase_q) && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || fire;

	assign r0       = regs_q[0];
	assign rsel     = regs_q[ri_s1];
	assign mem_addr = rsel[MEM_AW-1:0];
	assign mem_we   = fire && (func_s1 == OP_STORE);

	// length clamped to the program store depth
	assign len_eff = (WORD_W'(prog_len_q) > DEPTH_W) ? DEPTH_W : WORD_W'(prog_len_q);

	always_comb begin
		reg_we    = 1'b0;
		reg_wa    = ri_s1;
		reg_wd    = '0;
		pc_nx     = pc_q + WORD_W'(1);
		time_nx   = time_q;
		io_nx     = io_q;
		status_nx = ST_RUN;
		ovalid_nx = 1'b0;
		unique case (func_s1)
			OP_READ: begin
				reg_we = 1'b1; reg_wa = '0; reg_wd = val_s1;
				io_nx  = io_q + COST_IO;
			end
			OP_WRITE: begin
				ovalid_nx = 1'b1;
				io_nx     = io_q + COST_IO;
			end
			OP_LOAD: begin
				reg_we  = 1'b1; reg_wa = '0; reg_wd = mem_rd_q;
				time_nx = time_q + COST_MEM;
			end
			OP_STORE: begin
				time_nx = time_q + COST_MEM;
			end
			OP_ADD: begin
				reg_we  = 1'b1; reg_wa = '0; reg_wd = r0 + rsel;
				time_nx = time_q + COST_ARITH;
			end
			OP_SUB: begin
				reg_we  = 1'b1; reg_wa = '0;
				reg_wd  = (r0 >= rsel) ? r0 - rsel : '0;
				time_nx = time_q + COST_ARITH;
			end
			OP_GET: begin
				reg_we  = 1'b1; reg_wa = '0; reg_wd = rsel;
				time_nx = time_q + COST_SIMPLE;
			end
			OP_PUT: begin
				reg_we  = 1'b1; reg_wd = r0;
				time_nx = time_q + COST_SIMPLE;
			end
			OP_RST: begin
				reg_we  = 1'b1; reg_wd = '0;
				time_nx = time_q + COST_SIMPLE;
			end
			OP_INC: begin
				reg_we  = 1'b1; reg_wd = rsel + WORD_W'(1);
				time_nx = time_q + COST_SIMPLE;
			end
			OP_DEC: begin
				reg_we  = 1'b1;
				reg_wd  = (rsel != '0) ? rsel - WORD_W'(1) : '0;
				time_nx = time_q + COST_SIMPLE;
			end
			OP_SHL: begin
				reg_we  = 1'b1; reg_wd = {rsel[WORD_W-2:0], 1'b0};
				time_nx = time_q + COST_SIMPLE;
			end
			OP_SHR: begin
				reg_we  = 1'b1; reg_wd = {1'b0, rsel[WORD_W-1:1]};
				time_nx = time_q + COST_SIMPLE;
			end
			OP_JUMP: begin
				pc_nx   = WORD_W'(tgt_s1);
				time_nx = time_q + COST_SIMPLE;
			end
			OP_JPOS: begin
				if (r0 != '0) pc_nx = WORD_W'(tgt_s1);
				time_nx = time_q + COST_SIMPLE;
			end
			OP_JZERO: begin
				if (r0 == '0) pc_nx = WORD_W'(tgt_s1);
				time_nx = time_q + COST_SIMPLE;
			end
			OP_STRK: begin
				reg_we  = 1'b1; reg_wd = pc_q;
				time_nx = time_q + COST_SIMPLE;
			end
			OP_JUMPR: begin
				pc_nx   = rsel;
				time_nx = time_q + COST_SIMPLE;
			end
			OP_HALT: begin
				pc_nx     = pc_q;
				status_nx = ST_HALT;
			end
			default: begin
				// unused opcode: nothing changes
				pc_nx = pc_q;
			end
		endcase
		// out of range wins over halted
		if (pc_nx >= len_eff) status_nx = ST_ERR;
	end

	// ---------------- input register and load phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			phase_q <= valid_s1 && is_load && !fire;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1 <= s_tuser[4:0];
			ri_s1   <= s_tdata[2:0];
			tgt_s1  <= s_tdata[14:3];
			val_s1  <= s_tdata[78:15];
		end
	end

	// ---------------- data memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= r0;
		mem_rd_q <= mem[mem_addr];
	end

	// ---------------- architectural state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) regs_q[i] <= '0;
			pc_q       <= '0;
			time_q     <= '0;
			io_q       <= '0;
			prog_len_q <= LEN_W'(1);
		end else begin
			if (cfg_we) prog_len_q <= cfg_wdata;
			if (fire) begin
				if (reg_we) regs_q[reg_wa] <= reg_wd;
				pc_q   <= pc_nx;
				time_q <= time_nx;
				io_q   <= io_nx;
			end
		end
	end

	// ---------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else begin
			if (fire) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q <= status_nx;
			ovalid_q <= ovalid_nx;
			npc_q    <= pc_nx;
			oval_q   <= ovalid_nx ? r0 : '0;
			tcost_q  <= time_nx;
			iocost_q <= io_nx;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {iocost_q, tcost_q, oval_q, npc_q};
	assign m_tuser  = {ovalid_q, status_q};

	// ---------------- assertions
	a_phase_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> valid_s1 && is_load)
		else $error("load phase set without a load in s1");

	a_load_waits_read: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_load |-> $past(valid_s1) && $past(is_load))
		else $error("load executed without a prior memory read cycle");

	a_halt_keeps_counters: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (func_s1 == OP_HALT) |=> $stable(time_q) && $stable(io_q) && $stable(pc_q))
		else $error("halt changed pc or counters");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[1:0] == ST_RUN) || (m_tuser[1:0] == ST_HALT)
			|| (m_tuser[1:0] == ST_ERR))
		else $error("invalid status code on output");

	a_write_flag_status: assert property (@(posedge clk) disable iff (!arst_n)
		fire && ovalid_nx |-> status_nx != ST_HALT)
		else $error("write result flagged as halted");

endmodule
